>>> hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and functions of the AES-128 cipher unit
// Byte tables, round functions and the configuration register indexes.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned CfgIdxW   = 2;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENC_KEY_HIGH = 2'd0,
    REG_ENC_KEY_LOW  = 2'd1,
    REG_DEC_KEY_HIGH = 2'd2,
    REG_DEC_KEY_LOW  = 2'd3
  } cfg_reg_t;

  localparam byte_t RconEncFirst = 8'h01;
  localparam byte_t RconDecFirst = 8'h36;

  localparam logic [2047:0] SboxTab = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] InvSboxTab = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic byte_t sbox(input byte_t b);
    sbox = SboxTab[(255 - int'(b)) * 8 +: 8];
  endfunction

  function automatic byte_t inv_sbox(input byte_t b);
    inv_sbox = InvSboxTab[(255 - int'(b)) * 8 +: 8];
  endfunction

  function automatic byte_t xt(input byte_t b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block, byte 0 in the top bits
  function automatic byte_t gb(input blk_t s, input int i);
    gb = s[(15 - i) * 8 +: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t s, input logic dec);
    blk_t t;
    int   src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = dec ? ((c - r + 4) & 3) : ((c + r) & 3);
        t[(15 - (c * 4 + r)) * 8 +: 8] = dec ? inv_sbox(gb(s, src * 4 + r))
                                             : sbox(gb(s, src * 4 + r));
      end
    end
    sub_shift = t;
  endfunction

  function automatic blk_t mix(input blk_t s);
    blk_t  t;
    byte_t a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 16; c += 4) begin
      a0 = gb(s, c); a1 = gb(s, c + 1); a2 = gb(s, c + 2); a3 = gb(s, c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[(15 - c) * 8 +: 8]       = a0 ^ al ^ xt(a0 ^ a1);
      t[(15 - c - 1) * 8 +: 8]   = a1 ^ al ^ xt(a1 ^ a2);
      t[(15 - c - 2) * 8 +: 8]   = a2 ^ al ^ xt(a2 ^ a3);
      t[(15 - c - 3) * 8 +: 8]   = a3 ^ al ^ xt(a3 ^ a0);
    end
    mix = t;
  endfunction

  // inverse mix as pre-step u/v then forward mix
  function automatic blk_t inv_mix(input blk_t s);
    blk_t  t;
    byte_t a0, a1, a2, a3, u, v;
    t = s;
    for (int c = 0; c < 16; c += 4) begin
      a0 = gb(s, c); a1 = gb(s, c + 1); a2 = gb(s, c + 2); a3 = gb(s, c + 3);
      u = xt(xt(a0 ^ a2));
      v = xt(xt(a1 ^ a3));
      t[(15 - c) * 8 +: 8]     = a0 ^ u;
      t[(15 - c - 1) * 8 +: 8] = a1 ^ v;
      t[(15 - c - 2) * 8 +: 8] = a2 ^ u;
      t[(15 - c - 3) * 8 +: 8] = a3 ^ v;
    end
    inv_mix = mix(t);
  endfunction

  function automatic blk_t key_fwd(input blk_t k, input byte_t rc);
    blk_t  t;
    logic [31:0] w;
    w = {sbox(gb(k, 13)) ^ rc, sbox(gb(k, 14)), sbox(gb(k, 15)), sbox(gb(k, 12))};
    t[127:96] = k[127:96] ^ w;
    t[95:64]  = k[95:64] ^ t[127:96];
    t[63:32]  = k[63:32] ^ t[95:64];
    t[31:0]   = k[31:0] ^ t[63:32];
    key_fwd = t;
  endfunction

  function automatic blk_t key_bwd(input blk_t k, input byte_t rc);
    blk_t  t;
    t[31:0]   = k[31:0] ^ k[63:32];
    t[63:32]  = k[63:32] ^ k[95:64];
    t[95:64]  = k[95:64] ^ k[127:96];
    t[127:96] = k[127:96] ^ {sbox(t[23:16]) ^ rc, sbox(t[15:8]), sbox(t[7:0]),
                             sbox(t[31:24])};
    key_bwd = t;
  endfunction

  function automatic byte_t rc_next(input byte_t rc, input logic dec);
    if (dec) rc_next = rc[0] ? 8'h80 : {1'b0, rc[7:1]};
    else     rc_next = xt(rc);
  endfunction

endpackage

>>> hdl/aes_if.sv
// ----------------------------------------------------------------------------
// aes_if: valid/ready channels of the AES-128 cipher unit
// Input block channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, opcode, block_high, block_low, input ready);
  modport sink   (input valid, opcode, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        was_decrypt;
  modport source (output valid, out_high, out_low, was_decrypt, input ready);
  modport sink   (input valid, out_high, out_low, was_decrypt, output ready);
endinterface

interface aes_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [aes_pkg::CfgIdxW-1:0] index;
  logic [63:0]                data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/aes128_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// aes128_block_cipher_unit: pipelined AES-128 encrypt / decrypt
// Ten unrolled rounds with on-the-fly key schedule, one stage per round.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in       in   opcode, block_high, block_low
//  out      out  out_high, out_low, was_decrypt
//  cfg      in   index (0..3), data (64-bit key half)
//
//  Pipeline: key add stage plus one register stage per round. Throughput
//  one beat per cycle while the output is not stalled.
//  Stall: all stages advance together when the last stage is empty or taken;
//  a full last stage held by out.ready freezes the pipe, nothing dropped.
//  Reset (rst, sync) clears the valid bits and the four key registers.
//  Config is always accepted; write only while the pipe is empty.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit (
  input logic clk,
  input logic rst,
  aes_in_if.sink    in_ch,
  aes_out_if.source out_ch,
  aes_cfg_if.sink   cfg
);

  localparam int unsigned NStg = aes_pkg::NumRounds + 1;

  logic [63:0] enc_key_high, enc_key_low, dec_key_high, dec_key_low;

  // per stage: state, running round key, rcon, direction, valid
  aes_pkg::blk_t  st  [NStg];
  aes_pkg::blk_t  key [NStg];
  aes_pkg::byte_t rc  [NStg];
  logic           dec [NStg];
  logic           vld [NStg];

  logic adv;

  assign adv         = !vld[NStg-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg.ready   = 1'b1;

  assign out_ch.valid       = vld[NStg-1];
  assign out_ch.out_high    = st[NStg-1][127:64];
  assign out_ch.out_low     = st[NStg-1][63:0];
  assign out_ch.was_decrypt = dec[NStg-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_key_high <= '0;
      enc_key_low  <= '0;
      dec_key_high <= '0;
      dec_key_low  <= '0;
    end else if (cfg.valid) begin
      unique case (aes_pkg::cfg_reg_t'(cfg.index))
        aes_pkg::REG_ENC_KEY_HIGH: enc_key_high <= cfg.data;
        aes_pkg::REG_ENC_KEY_LOW:  enc_key_low  <= cfg.data;
        aes_pkg::REG_DEC_KEY_HIGH: dec_key_high <= cfg.data;
        aes_pkg::REG_DEC_KEY_LOW:  dec_key_low  <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage 0: initial key add
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_ch.valid;
    end
    if (adv) begin
      dec[0] <= in_ch.opcode;
      key[0] <= in_ch.opcode ? {dec_key_high, dec_key_low} : {enc_key_high, enc_key_low};
      rc[0]  <= in_ch.opcode ? aes_pkg::RconDecFirst : aes_pkg::RconEncFirst;
      st[0]  <= {in_ch.block_high, in_ch.block_low} ^
                (in_ch.opcode ? {dec_key_high, dec_key_low}
                              : {enc_key_high, enc_key_low});
    end
  end

  // round stages
  for (genvar g = 1; g < NStg; g++) begin : g_rnd
    aes_pkg::blk_t pre, sb, mx, nk;
    always_comb begin
      // decrypt applies inverse mix before sub/shift except on round 1
      pre = (dec[g-1] && g != 1) ? aes_pkg::inv_mix(st[g-1]) : st[g-1];
      sb  = aes_pkg::sub_shift(pre, dec[g-1]);
      mx  = (!dec[g-1] && g != NStg - 1) ? aes_pkg::mix(sb) : sb;
      nk  = dec[g-1] ? aes_pkg::key_bwd(key[g-1], rc[g-1])
                     : aes_pkg::key_fwd(key[g-1], rc[g-1]);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (adv) begin
        vld[g] <= vld[g-1];
      end
      if (adv) begin
        dec[g] <= dec[g-1];
        key[g] <= nk;
        rc[g]  <= aes_pkg::rc_next(rc[g-1], dec[g-1]);
        st[g]  <= mx ^ nk;
      end
    end
  end

endmodule

>>> hdl/aes_chk.sv
// ----------------------------------------------------------------------------
// aes_chk: port checker for the AES-128 cipher unit
// Pipeline flow properties seen at the ports, bound to the top level.
// ----------------------------------------------------------------------------
module aes_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic        cfg_ready
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_high))
    else $error("result changed under stall");

  // input is taken whenever the output side is free
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked without stall");

  // a full, stalled output blocks the input
  a_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during stall");

  a_cfg: assert property (@(posedge clk) cfg_ready)
    else $error("config not ready");

  // no result right after reset
  a_rst: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind aes128_block_cipher_unit aes_chk u_aes_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_high(out_ch.out_high), .cfg_ready(cfg.ready)
);
